### rtl/sto_pkg.sv
// ----------------------------------------------------------------------------
// Station table package
// Shared types and constants for the station table with oldest replacement.
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam int          TABLE_ENTRIES_DEF = 16;
    localparam logic [31:0] WINDOW_RESET      = 32'd60000;

    localparam logic FUNC_NOTE  = 1'b0;
    localparam logic FUNC_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_UPDATED  = 2'd0,
        OUTCOME_CLAIMED  = 2'd1,
        OUTCOME_REPLACED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic        func;
        logic [23:0] station_id;
        logic [7:0]  radio_channel;
        logic [31:0] relayed_count;
        logic [15:0] uptime_seconds;
        logic [31:0] time_now_ms;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  slot_used;
        logic [1:0]  note_outcome;
        logic [8:0]  online_total;
    } t_out_item;

    typedef struct packed {
        logic [23:0] station;
        logic [7:0]  channel;
        logic [31:0] relayed;
        logic [15:0] uptime;
        logic [31:0] last_heard;
    } t_entry;

    typedef struct packed {
        logic        match_hit;
        logic [7:0]  match_idx;
        logic        free_hit;
        logic [7:0]  free_idx;
        logic [7:0]  victim_idx;
        logic [8:0]  count;
    } t_scan_res;

endpackage

### rtl/sto_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sto_scan.sv
// ----------------------------------------------------------------------------
// Station table scan unit
// Evaluates one table entry per cycle: identifier match, first free slot,
// oldest entry and online count.
// ----------------------------------------------------------------------------
module sto_scan #(
    parameter int TABLE_ENTRIES = sto_pkg::TABLE_ENTRIES_DEF,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic               i_ev_valid,
    input  logic [IW-1:0]      i_ev_idx,
    input  logic               i_ev_live,
    input  sto_pkg::t_entry    i_entry,
    input  logic [23:0]        i_station_id,
    input  logic [31:0]        i_time_now_ms,
    input  logic [31:0]        i_window,
    output sto_pkg::t_scan_res o_res
);

    logic [31:0]        age;
    logic [31:0]        r_oldest;
    sto_pkg::t_scan_res r_res;

    assign age = i_time_now_ms - i_entry.last_heard;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res.match_hit <= 1'b0;
            r_res.free_hit  <= 1'b0;
            r_res.count     <= '0;
            r_oldest        <= '0;
        end else if (i_ev_valid) begin
            if (i_ev_live && (i_entry.station == i_station_id) && !r_res.match_hit) begin
                r_res.match_hit <= 1'b1;
                r_res.match_idx <= 8'(i_ev_idx);
            end
            if (!i_ev_live && !r_res.free_hit) begin
                r_res.free_hit <= 1'b1;
                r_res.free_idx <= 8'(i_ev_idx);
            end
            if (i_ev_live && (age >= r_oldest)) begin
                r_oldest         <= age;
                r_res.victim_idx <= 8'(i_ev_idx);
            end
            if (i_ev_live && (age <= i_window)) begin
                r_res.count <= r_res.count + 9'd1;
            end
        end
    end

    assign o_res = r_res;

endmodule

### rtl/station_table_oldest_replace_top.sv
// ----------------------------------------------------------------------------
// Station table with oldest replacement, top level
// An input item is taken only in the idle state; the scan reads the table memory
// one entry per cycle, and the finish step waits until the output register is free
// before it registers the result and returns to idle.
// Reset clears all valid marks and loads the online window with 60000;
// record fields stay undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module station_table_oldest_replace_top #(
    parameter int TABLE_ENTRIES = sto_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sto_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sto_pkg::t_out_item o_out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(sto_pkg::t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [31:0]            r_window;
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    sto_pkg::t_in_item      r_item;
    logic [CW-1:0]          r_rd_cnt;
    logic                   r_ev_valid;
    logic [IW-1:0]          r_ev_idx;
    logic                   r_out_valid;
    sto_pkg::t_out_item     r_out;

    logic                   in_take;
    logic                   finish_go;
    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    sto_pkg::t_entry        wr_entry;
    sto_pkg::t_entry        rd_entry;
    logic [EW-1:0]          rd_bits;
    sto_pkg::t_scan_res     scan_res;
    logic [7:0]             pick_slot;
    sto_pkg::t_outcome      pick_outcome;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign finish_go  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    assign ram_we     = finish_go && (r_item.func == sto_pkg::FUNC_NOTE);
    assign ram_raddr  = r_rd_cnt[IW-1:0];

    always_comb begin
        priority if (scan_res.match_hit) begin
            pick_slot    = scan_res.match_idx;
            pick_outcome = sto_pkg::OUTCOME_UPDATED;
        end else if (scan_res.free_hit) begin
            pick_slot    = scan_res.free_idx;
            pick_outcome = sto_pkg::OUTCOME_CLAIMED;
        end else begin
            pick_slot    = scan_res.victim_idx;
            pick_outcome = sto_pkg::OUTCOME_REPLACED;
        end
    end

    always_comb begin
        wr_entry.station    = r_item.station_id;
        wr_entry.channel    = r_item.radio_channel;
        wr_entry.relayed    = r_item.relayed_count;
        wr_entry.uptime     = r_item.uptime_seconds;
        wr_entry.last_heard = r_item.time_now_ms;
    end

    assign rd_entry = sto_pkg::t_entry'(rd_bits);

    sto_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pick_slot[IW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bits)
    );

    sto_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_start       (in_take),
        .i_ev_valid    (r_ev_valid),
        .i_ev_idx      (r_ev_idx),
        .i_ev_live     (r_slot_valid[r_ev_idx]),
        .i_entry       (rd_entry),
        .i_station_id  (r_item.station_id),
        .i_time_now_ms (r_item.time_now_ms),
        .i_window      (r_window),
        .o_res         (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= sto_pkg::WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_rd_cnt     <= '0;
            r_ev_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !finish_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_item   <= i_in_data;
                        r_rd_cnt <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_cnt == CW'(TABLE_ENTRIES)) begin
                        r_ev_valid <= 1'b0;
                        r_state    <= S_FINISH;
                    end else begin
                        r_ev_valid <= 1'b1;
                        r_ev_idx   <= r_rd_cnt[IW-1:0];
                        r_rd_cnt   <= r_rd_cnt + CW'(1);
                    end
                end
                S_FINISH: begin
                    if (finish_go) begin
                        r_out_valid        <= 1'b1;
                        r_out.result_kind  <= r_item.func;
                        if (r_item.func == sto_pkg::FUNC_NOTE) begin
                            r_slot_valid[pick_slot[IW-1:0]] <= 1'b1;
                            r_out.slot_used    <= pick_slot;
                            r_out.note_outcome <= pick_outcome;
                            r_out.online_total <= '0;
                        end else begin
                            r_out.slot_used    <= '0;
                            r_out.note_outcome <= sto_pkg::OUTCOME_UPDATED;
                            r_out.online_total <= scan_res.count;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FINISH)
        else $error("Result raised outside the finish step.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_rd_cnt <= CW'(TABLE_ENTRIES))
        else $error("Scan counter ran past the table.");

    a_slot_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == sto_pkg::FUNC_NOTE)
            |-> 9'(o_out_data.slot_used) < 9'(TABLE_ENTRIES))
        else $error("Note transaction reported a slot outside the table.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == sto_pkg::FUNC_COUNT)
            |-> o_out_data.online_total <= 9'(TABLE_ENTRIES))
        else $error("Online count exceeds the table size.");

endmodule
